// File: design/perceptron_classify_train_defines.svh
// ----------------------------------------------------------------------------
// perceptron_classify_train_defines.svh
// Assertion macros for the perceptron classify and train block.
// ----------------------------------------------------------------------------
`ifndef PERCEPTRON_CLASSIFY_TRAIN_DEFINES_SVH
`define PERCEPTRON_CLASSIFY_TRAIN_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define PCT_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("perceptron_classify_train: implication check failed");

// next-cycle implication
`define PCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("perceptron_classify_train: next-cycle check failed");

`endif

// File: design/pct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_pkg
// Shared constants, register indexes, sequencer state and control types.
// ----------------------------------------------------------------------------
package pct_pkg;

	localparam int MAX_LEN      = 16;
	localparam int FEATURE_BITS = 16;
	localparam int LEN_BITS     = 5;
	localparam int LEVEL_BITS   = 36;
	localparam int RATE_BITS    = 16;
	localparam int CFG_BITS     = 36;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [LEN_BITS-1:0]   VECTOR_LENGTH_RST  = 5'd16;
	localparam logic [LEVEL_BITS-1:0] DECISION_LEVEL_RST = '0;
	localparam logic [RATE_BITS-1:0]  LEARN_RATE_RST     = 16'd22938;

	localparam logic [CFG_IDX_BITS-1:0] REG_VECTOR_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DECISION_LEVEL = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEARN_RATE     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AMUL,
		ST_AADD,
		ST_DECIDE,
		ST_TREAD,
		ST_TMUL,
		ST_TUPD
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic load_item;
		logic mul_acc;
		logic mul_train;
		logic sum_update;
		logic cnt_inc;
		logic out_load;
		logic wt_write;
		logic clear_vec;
		logic i_inc;
		logic rd_train;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic final_feat;
		logic train_needed;
		logic out_free;
		logic i_last;
	} status_t;

endpackage

// File: design/pct_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_alu
// Shared multiplier with registered product, plus the saturating sum update
// and the rounded, saturating weight update that follow it.
// ----------------------------------------------------------------------------
module pct_alu #(
	parameter int FEATURE_BITS = pct_pkg::FEATURE_BITS
) (
	input  logic                           clk,
	input  pct_pkg::ctrl_t                 ctrl,
	input  logic signed [FEATURE_BITS-1:0] acc_feature,
	input  logic signed [FEATURE_BITS-1:0] weight,
	input  logic [pct_pkg::RATE_BITS-1:0]  rate,
	input  logic signed [FEATURE_BITS-1:0] train_feature,
	input  logic signed [2*FEATURE_BITS+4:0] sum,
	input  logic                           up,
	output logic signed [2*FEATURE_BITS+4:0] sum_next,
	output logic signed [FEATURE_BITS-1:0] weight_next
);

	localparam int FB = FEATURE_BITS;
	localparam int RB = pct_pkg::RATE_BITS;
	localparam int MA = (FB > RB + 1) ? FB : RB + 1;
	localparam int PW = MA + FB;
	localparam int SW = 2 * FB + 5;
	localparam int DW = PW + 1 - RB;
	localparam int UW = DW + 1;

	localparam logic signed [PW:0] ROUND =
		{{(PW - RB + 1){1'b0}}, 1'b1, {(RB - 1){1'b0}}};
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};
	localparam logic signed [UW-1:0] W_MAX = {{(UW - FB + 1){1'b0}}, {(FB - 1){1'b1}}};
	localparam logic signed [UW-1:0] W_MIN = {{(UW - FB + 1){1'b1}}, {(FB - 1){1'b0}}};

	logic signed [MA-1:0] mul_a;
	logic signed [FB-1:0] mul_b;
	logic signed [PW-1:0] prod_q;
	logic signed [SW:0]   sum_wide;
	logic signed [PW:0]   rnd;
	logic signed [DW-1:0] delta;
	logic signed [UW-1:0] w_wide;

	always_comb begin
		if (ctrl.mul_train) begin
			mul_a = $signed({{(MA - RB){1'b0}}, rate});
			mul_b = train_feature;
		end else begin
			mul_a = MA'(acc_feature);
			mul_b = weight;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_acc || ctrl.mul_train) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// a feature times a weight always fits in 2*FB bits
	always_comb begin
		sum_wide = (SW + 1)'(sum) + (SW + 1)'($signed(prod_q[2*FB-1:0]));
		if (sum_wide[SW] != sum_wide[SW-1]) begin
			sum_next = sum_wide[SW] ? S_MIN : S_MAX;
		end else begin
			sum_next = sum_wide[SW-1:0];
		end
	end

	// round to nearest, ties up, then apply the error sign
	always_comb begin
		rnd    = (PW + 1)'(prod_q) + ROUND;
		delta  = $signed(rnd[PW:RB]);
		w_wide = up ? (UW'(weight) + UW'(delta)) : (UW'(weight) - UW'(delta));
		if (w_wide > W_MAX) begin
			weight_next = W_MAX[FB-1:0];
		end else if (w_wide < W_MIN) begin
			weight_next = W_MIN[FB-1:0];
		end else begin
			weight_next = w_wide[FB-1:0];
		end
	end

endmodule

// File: design/pct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_ctrl
// Sequencer: accumulate one feature, decide the class, walk the weights.
// ----------------------------------------------------------------------------
module pct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  pct_pkg::status_t  status,
	output pct_pkg::ctrl_t    ctrl,
	output pct_pkg::state_t   state
);

	pct_pkg::state_t state_q;
	pct_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pct_pkg::ST_IDLE: begin
				if (status.in_valid) state_d = pct_pkg::ST_AMUL;
			end
			pct_pkg::ST_AMUL: state_d = pct_pkg::ST_AADD;
			pct_pkg::ST_AADD: begin
				state_d = status.final_feat ? pct_pkg::ST_DECIDE : pct_pkg::ST_IDLE;
			end
			pct_pkg::ST_DECIDE: begin
				if (status.out_free) begin
					state_d = status.train_needed ? pct_pkg::ST_TREAD : pct_pkg::ST_IDLE;
				end
			end
			pct_pkg::ST_TREAD: state_d = pct_pkg::ST_TMUL;
			pct_pkg::ST_TMUL:  state_d = pct_pkg::ST_TUPD;
			pct_pkg::ST_TUPD: begin
				state_d = status.i_last ? pct_pkg::ST_IDLE : pct_pkg::ST_TREAD;
			end
			default: state_d = pct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			pct_pkg::ST_IDLE: begin
				ctrl.in_ready  = 1'b1;
				ctrl.load_item = status.in_valid;
			end
			pct_pkg::ST_AMUL: ctrl.mul_acc = 1'b1;
			pct_pkg::ST_AADD: begin
				ctrl.sum_update = 1'b1;
				ctrl.cnt_inc    = !status.final_feat;
			end
			pct_pkg::ST_DECIDE: begin
				// hold the decision until the output slot frees up
				ctrl.out_load  = status.out_free;
				ctrl.clear_vec = status.out_free && !status.train_needed;
			end
			pct_pkg::ST_TREAD: ctrl.rd_train = 1'b1;
			pct_pkg::ST_TMUL: begin
				ctrl.rd_train  = 1'b1;
				ctrl.mul_train = 1'b1;
			end
			pct_pkg::ST_TUPD: begin
				ctrl.rd_train  = 1'b1;
				ctrl.wt_write  = 1'b1;
				ctrl.i_inc     = !status.i_last;
				ctrl.clear_vec = status.i_last;
			end
			default: ctrl = '0;
		endcase
	end

	assign state = state_q;

endmodule

// File: design/perceptron_classify_train.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perceptron_classify_train
// Single-layer perceptron: classify a feature vector, optionally train.
// ----------------------------------------------------------------------------
// One feature arrives per input item and is multiplied by its weight on a
// single shared multiplier. An item that does not end a vector goes through
// accept with weight read, multiply and accumulate before the next item is
// taken. The final feature then adds a decide step that compares the sum with
// decision_level, held while the previous guess still waits at the output. When a
// train command meets a wrong guess, the sequencer then walks the n features of
// the vector through the same multiplier, one weight at a time (read, multiply
// by learn_rate, round and write back). The input is not ready during any of
// this. Weights start at zero after reset through per-entry valid bits; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module perceptron_classify_train #(
	parameter int MAX_LEN      = pct_pkg::MAX_LEN,
	parameter int FEATURE_BITS = pct_pkg::FEATURE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [pct_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [pct_pkg::CFG_BITS-1:0]        wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic signed [FEATURE_BITS-1:0]      feature,
	input  logic                                expected_class,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                guess
);

	localparam int IW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW   = $clog2(MAX_LEN + 1);
	localparam int LW   = (CW > pct_pkg::LEN_BITS) ? CW : pct_pkg::LEN_BITS;
	localparam int SW   = 2 * FEATURE_BITS + 5;
	localparam int CMPW = (SW > pct_pkg::LEVEL_BITS) ? SW : pct_pkg::LEVEL_BITS;

	// configuration
	logic [pct_pkg::LEN_BITS-1:0]          vector_length_q;
	logic signed [pct_pkg::LEVEL_BITS-1:0] decision_level_q;
	logic [pct_pkg::RATE_BITS-1:0]         learn_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_length_q  <= pct_pkg::VECTOR_LENGTH_RST;
			decision_level_q <= pct_pkg::DECISION_LEVEL_RST;
			learn_rate_q     <= pct_pkg::LEARN_RATE_RST;
		end else if (wr_en) begin
			case (wr_index)
				pct_pkg::REG_VECTOR_LENGTH:  vector_length_q  <= wr_data[pct_pkg::LEN_BITS-1:0];
				pct_pkg::REG_DECISION_LEVEL: decision_level_q <= wr_data[pct_pkg::LEVEL_BITS-1:0];
				pct_pkg::REG_LEARN_RATE:     learn_rate_q     <= wr_data[pct_pkg::RATE_BITS-1:0];
				default: ;
			endcase
		end
	end

	pct_pkg::ctrl_t   ctrl;
	pct_pkg::status_t status;
	pct_pkg::state_t  state;

	logic signed [FEATURE_BITS-1:0] feature_q;
	logic                           train_q;
	logic                           expected_q;
	logic signed [SW-1:0]           sum_q;
	logic signed [SW-1:0]           sum_next;
	logic [IW-1:0]                  count_q;
	logic [IW-1:0]                  i_q;
	logic                           out_valid_q;
	logic                           guess_q;
	logic                           guess_c;
	logic [LW-1:0]                  eff_len;
	logic [LW-1:0]                  vl_ext;
	logic [LW-1:0]                  n_feat;

	// memories
	logic signed [FEATURE_BITS-1:0] fbuf_mem [MAX_LEN];
	logic signed [FEATURE_BITS-1:0] wt_mem   [MAX_LEN];
	logic [MAX_LEN-1:0]             wt_valid_q;
	logic signed [FEATURE_BITS-1:0] fbuf_rd_q;
	logic signed [FEATURE_BITS-1:0] wt_rd_q;
	logic                           wt_rdv_q;
	logic signed [FEATURE_BITS-1:0] weight_eff;
	logic signed [FEATURE_BITS-1:0] weight_next;
	logic [IW-1:0]                  wt_raddr;

	assign wt_raddr   = ctrl.rd_train ? i_q : count_q;
	assign weight_eff = wt_rdv_q ? wt_rd_q : '0;

	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			fbuf_mem[count_q] <= feature;
		end
		fbuf_rd_q <= fbuf_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (ctrl.wt_write) begin
			wt_mem[i_q] <= weight_next;
		end
		wt_rd_q <= wt_mem[wt_raddr];
	end

	// a weight never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wt_valid_q <= '0;
			wt_rdv_q   <= 1'b0;
		end else begin
			if (ctrl.wt_write) wt_valid_q[i_q] <= 1'b1;
			wt_rdv_q <= wt_valid_q[wt_raddr];
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			feature_q  <= feature;
			train_q    <= command;
			expected_q <= expected_class;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			i_q     <= '0;
		end else begin
			if (ctrl.clear_vec) begin
				sum_q   <= '0;
				count_q <= '0;
				i_q     <= '0;
			end else begin
				if (ctrl.sum_update) sum_q <= sum_next;
				if (ctrl.cnt_inc) count_q <= count_q + 1'b1;
				if (ctrl.i_inc) i_q <= i_q + 1'b1;
			end
		end
	end

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) guess_q <= guess_c;
	end

	// effective vector length: zero acts as one, clamp at MAX_LEN
	always_comb begin
		vl_ext = LW'(vector_length_q);
		if (vl_ext == '0) begin
			eff_len = LW'(1);
		end else if (vl_ext > LW'(MAX_LEN)) begin
			eff_len = LW'(MAX_LEN);
		end else begin
			eff_len = vl_ext;
		end
	end

	assign n_feat  = LW'(count_q) + LW'(1);
	assign guess_c = (CMPW'(sum_q) >= CMPW'(decision_level_q));

	assign status.in_valid     = in_valid;
	assign status.final_feat   = (n_feat >= eff_len);
	assign status.train_needed = train_q && (expected_q != guess_c);
	assign status.out_free     = !out_valid_q || out_ready;
	assign status.i_last       = (i_q == count_q);

	pct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl),
		.state  (state)
	);

	// err > 0 exactly when the stored guess was 0
	pct_alu #(
		.FEATURE_BITS (FEATURE_BITS)
	) u_alu (
		.clk           (clk),
		.ctrl          (ctrl),
		.acc_feature   (feature_q),
		.weight        (weight_eff),
		.rate          (learn_rate_q),
		.train_feature (fbuf_rd_q),
		.sum           (sum_q),
		.up            (!guess_q),
		.sum_next      (sum_next),
		.weight_next   (weight_next)
	);

	assign in_ready  = ctrl.in_ready;
	assign out_valid = out_valid_q;
	assign guess     = guess_q;

`include "perceptron_classify_train_defines.svh"

	`PCT_ASSERT_NEXT(a_accept_to_mul, in_valid && in_ready, state == pct_pkg::ST_AMUL)
	`PCT_ASSERT_IMPLIES(a_write_needs_train, ctrl.wt_write, train_q)
	`PCT_ASSERT_IMPLIES(a_result_from_decide, $rose(out_valid), $past(state == pct_pkg::ST_DECIDE))

endmodule
